@@ hw/rtl/tss_pkg.sv @@
package tss_pkg;

    // build-time limits
    localparam int MAX_TERMS_DEF = 10;
    localparam int TERMS_LIM     = 16;

    // field and datapath widths
    localparam int ANGLE_W = 32;
    localparam int SINE_W  = 32;
    localparam int CNT_W   = 4;
    localparam int HALF_W  = 32;
    localparam int PW_W    = 64;
    localparam int PROD_W  = 128;
    localparam int TERM_W  = 53;
    localparam int SUM_W   = 64;
    localparam int RND_SH  = 10;

    localparam logic [CNT_W-1:0] TERM_COUNT_RST = CNT_W'(10);

    // scaled reciprocal factorials, c_k = floor(c_(k-1) * 64 / ((2k)(2k+1))), Q9.52
    localparam logic [PROD_W-1:0] C00 = 128'd8 << 52;
    localparam logic [PROD_W-1:0] C01 = (C00 * 128'd64) / 128'd6;
    localparam logic [PROD_W-1:0] C02 = (C01 * 128'd64) / 128'd20;
    localparam logic [PROD_W-1:0] C03 = (C02 * 128'd64) / 128'd42;
    localparam logic [PROD_W-1:0] C04 = (C03 * 128'd64) / 128'd72;
    localparam logic [PROD_W-1:0] C05 = (C04 * 128'd64) / 128'd110;
    localparam logic [PROD_W-1:0] C06 = (C05 * 128'd64) / 128'd156;
    localparam logic [PROD_W-1:0] C07 = (C06 * 128'd64) / 128'd210;
    localparam logic [PROD_W-1:0] C08 = (C07 * 128'd64) / 128'd272;
    localparam logic [PROD_W-1:0] C09 = (C08 * 128'd64) / 128'd342;
    localparam logic [PROD_W-1:0] C10 = (C09 * 128'd64) / 128'd420;
    localparam logic [PROD_W-1:0] C11 = (C10 * 128'd64) / 128'd506;
    localparam logic [PROD_W-1:0] C12 = (C11 * 128'd64) / 128'd600;
    localparam logic [PROD_W-1:0] C13 = (C12 * 128'd64) / 128'd702;
    localparam logic [PROD_W-1:0] C14 = (C13 * 128'd64) / 128'd812;
    localparam logic [PROD_W-1:0] C15 = (C14 * 128'd64) / 128'd930;
    localparam logic [PROD_W-1:0] C16 = (C15 * 128'd64) / 128'd1056;

    localparam logic [PW_W-1:0] COEF_TABLE [0:TERMS_LIM] = '{
        C00[PW_W-1:0], C01[PW_W-1:0], C02[PW_W-1:0], C03[PW_W-1:0],
        C04[PW_W-1:0], C05[PW_W-1:0], C06[PW_W-1:0], C07[PW_W-1:0],
        C08[PW_W-1:0], C09[PW_W-1:0], C10[PW_W-1:0], C11[PW_W-1:0],
        C12[PW_W-1:0], C13[PW_W-1:0], C14[PW_W-1:0], C15[PW_W-1:0],
        C16[PW_W-1:0]
    };

    // payload handed from cell to cell
    typedef struct packed {
        logic                    neg;
        logic [PW_W-1:0]         u2;
        logic [PW_W-1:0]         pw;
        logic signed [SUM_W-1:0] sum;
    } tss_link_t;

endpackage

@@ hw/rtl/tss_front.sv @@
module tss_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic                          in_valid,
    input  logic [tss_pkg::ANGLE_W-1:0]   angle,
    output logic                          out_valid,
    output tss_pkg::tss_link_t            out_link
);
    import tss_pkg::*;

    logic                 v1_reg;
    logic                 v2_reg;
    logic                 neg_reg;
    logic [ANGLE_W-1:0]   mag_reg;
    logic [ANGLE_W-1:0]   mag_next;
    logic [2*ANGLE_W-1:0] sq;
    tss_link_t            link_reg;
    tss_link_t            link_next;

    // magnitude of the angle, most negative code gives 2^31
    assign mag_next = angle[ANGLE_W-1] ? (~angle + 1'b1) : angle;

    // u = |x|/8 in Q1.63, u^2 exact as 2*mag^2
    assign sq = mag_reg * mag_reg;

    always_comb
    begin
        link_next.neg = neg_reg;
        link_next.u2  = {sq[2*ANGLE_W-2:0], 1'b0};
        link_next.pw  = {mag_reg, {(PW_W-ANGLE_W){1'b0}}};
        link_next.sum = '0;
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            neg_reg  <= angle[ANGLE_W-1];
            mag_reg  <= mag_next;
            link_reg <= link_next;
        end
    end

    assign out_valid = v2_reg;
    assign out_link  = link_reg;

endmodule

@@ hw/rtl/tss_cell.sv @@
module tss_cell #(
    parameter int K = 0
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  logic [tss_pkg::CNT_W-1:0]   term_count,
    input  logic                        in_valid,
    input  tss_pkg::tss_link_t          in_link,
    output logic                        out_valid,
    output tss_pkg::tss_link_t          out_link
);
    import tss_pkg::*;

    localparam logic [PW_W-1:0]  COEF     = COEF_TABLE[K];
    localparam logic [CNT_W:0]   K_IDX    = (CNT_W+1)'(K);
    localparam bit               SUBTRACT = (K % 2) == 1;
    localparam int               TPAD     = SUM_W - TERM_W;

    logic [HALF_W-1:0]   a_lo, a_hi, b_lo, b_hi;
    logic [HALF_W-1:0]   c_lo, c_hi;
    logic                use_term;

    // stage 1: partial products
    logic                v1_reg, v2_reg, v3_reg;
    logic [2*HALF_W-1:0] tc_ll_reg, tc_lh_reg, tc_hl_reg, tc_hh_reg;
    logic [2*HALF_W-1:0] pp_ll_reg, pp_lh_reg, pp_hl_reg, pp_hh_reg;
    tss_link_t           l1_reg;

    // stage 2: assembled products
    logic [PROD_W-1:0]   prod_t, prod_p;
    logic [TERM_W-1:0]   term_reg, term_next;
    tss_link_t           l2_reg, l2_next;

    // stage 3: accumulation
    logic [SUM_W-1:0]    term_ext;
    tss_link_t           l3_reg, l3_next;

    assign a_lo = in_link.pw[HALF_W-1:0];
    assign a_hi = in_link.pw[PW_W-1:HALF_W];
    assign b_lo = in_link.u2[HALF_W-1:0];
    assign b_hi = in_link.u2[PW_W-1:HALF_W];
    assign c_lo = COEF[HALF_W-1:0];
    assign c_hi = COEF[PW_W-1:HALF_W];

    // a term above the configured last index contributes nothing
    assign use_term = ({1'b0, term_count} >= K_IDX);

    // product sums, term is pw*c >> 75, next power is pw*u2 >> 63
    always_comb
    begin
        prod_t = {tc_hh_reg, {(2*HALF_W){1'b0}}}
               + {{HALF_W{1'b0}}, tc_lh_reg, {HALF_W{1'b0}}}
               + {{HALF_W{1'b0}}, tc_hl_reg, {HALF_W{1'b0}}}
               + {{(2*HALF_W){1'b0}}, tc_ll_reg};
        prod_p = {pp_hh_reg, {(2*HALF_W){1'b0}}}
               + {{HALF_W{1'b0}}, pp_lh_reg, {HALF_W{1'b0}}}
               + {{HALF_W{1'b0}}, pp_hl_reg, {HALF_W{1'b0}}}
               + {{(2*HALF_W){1'b0}}, pp_ll_reg};
        term_next = use_term ? prod_t[PROD_W-1 -: TERM_W] : '0;
        l2_next    = l1_reg;
        l2_next.pw = prod_p[PROD_W-2 -: PW_W];
    end

    // alternating signs, odd terms subtract
    assign term_ext = {{TPAD{1'b0}}, term_reg};

    always_comb
    begin
        l3_next = l2_reg;
        if (SUBTRACT)
        begin
            l3_next.sum = l2_reg.sum - $signed(term_ext);
        end
        else
        begin
            l3_next.sum = l2_reg.sum + $signed(term_ext);
        end
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tc_ll_reg <= a_lo * c_lo;
            tc_lh_reg <= a_lo * c_hi;
            tc_hl_reg <= a_hi * c_lo;
            tc_hh_reg <= a_hi * c_hi;
            pp_ll_reg <= a_lo * b_lo;
            pp_lh_reg <= a_lo * b_hi;
            pp_hl_reg <= a_hi * b_lo;
            pp_hh_reg <= a_hi * b_hi;
            l1_reg    <= in_link;
            term_reg  <= term_next;
            l2_reg    <= l2_next;
            l3_reg    <= l3_next;
        end
    end

    assign out_valid = v3_reg;
    assign out_link  = l3_reg;

endmodule

@@ hw/rtl/tss_back.sv @@
module tss_back (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         en,
    input  logic                         in_valid,
    input  tss_pkg::tss_link_t           in_link,
    output logic                         out_valid,
    output logic [tss_pkg::SINE_W-1:0]   sine,
    output logic                         saturated
);
    import tss_pkg::*;

    localparam int              R_W     = SUM_W - RND_SH;
    localparam logic [SUM_W-1:0] HALF_LSB = SUM_W'(1) << (RND_SH - 1);
    localparam logic [R_W-1:0]  POS_LIM = R_W'(64'h0000_0000_7FFF_FFFF);
    localparam logic [R_W-1:0]  NEG_LIM = R_W'(64'h0000_0000_8000_0000);

    logic              v1_reg, v2_reg, v3_reg;
    logic [SUM_W-1:0]  mag_reg, mag_next;
    logic              flip1_reg, flip2_reg, flip_next;
    logic [SUM_W-1:0]  rsum;
    logic [R_W-1:0]    r_reg;
    logic              neg_out;
    logic [R_W-1:0]    lim;
    logic              sat_next;
    logic [R_W-1:0]    rv;
    logic [SINE_W-1:0] sine_next;
    logic [SINE_W-1:0] sine_reg;
    logic              sat_reg;

    // magnitude of the sum and the combined sign
    assign mag_next  = in_link.sum[SUM_W-1] ? (~in_link.sum + 1'b1) : in_link.sum;
    assign flip_next = in_link.sum[SUM_W-1] ^ in_link.neg;

    // round to nearest, ties away from zero
    assign rsum = mag_reg + HALF_LSB;

    // clamp and apply the sign
    always_comb
    begin
        neg_out   = flip2_reg && (r_reg != '0);
        lim       = neg_out ? NEG_LIM : POS_LIM;
        sat_next  = r_reg > lim;
        rv        = sat_next ? lim : r_reg;
        sine_next = neg_out ? (~rv[SINE_W-1:0] + 1'b1) : rv[SINE_W-1:0];
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mag_reg   <= mag_next;
            flip1_reg <= flip_next;
            r_reg     <= rsum[SUM_W-1:RND_SH];
            flip2_reg <= flip1_reg;
            sine_reg  <= sine_next;
            sat_reg   <= sat_next;
        end
    end

    assign out_valid = v3_reg;
    assign sine      = sine_reg;
    assign saturated = sat_reg;

endmodule

@@ hw/rtl/taylor_series_sine.sv @@
// channel  | side   | payload
// s_*      | in     | tdata[31:0] angle, signed Q4.28 radians
// m_*      | out    | tdata[31:0] sine, signed Q2.30; tuser[0] saturated
// cfg_*    | in     | data[3:0] term_count, index of last series term
//
// one angle per cycle while the pipeline is not held; the depth is set by the row of
// term cells, three stages each around split 64x64 products
// reset clears all valid bits and loads term_count with 10
// the whole pipeline holds while a result sits in the output register untaken;
// a new beat enters in any cycle the output register is empty or being read
module taylor_series_sine #(
    parameter int MAX_TERMS = tss_pkg::MAX_TERMS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [tss_pkg::ANGLE_W-1:0]   s_tdata,   // [31:0] angle
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [tss_pkg::SINE_W-1:0]    m_tdata,   // [31:0] sine
    output logic                          m_tuser,   // [0] saturated
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [tss_pkg::CNT_W-1:0]     cfg_data
);
    import tss_pkg::*;

    logic             en;
    logic [CNT_W-1:0] term_count_reg;
    tss_link_t        link       [0:MAX_TERMS+1];
    logic             link_valid [0:MAX_TERMS+1];

    // configuration register
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            term_count_reg <= TERM_COUNT_RST;
        end
        else if (cfg_valid)
        begin
            term_count_reg <= cfg_data;
        end
    end

    // pipeline advances unless a result waits untaken
    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    tss_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s_tvalid),
        .angle     (s_tdata),
        .out_valid (link_valid[0]),
        .out_link  (link[0])
    );

    // one cell per series term
    for (genvar k = 0; k <= MAX_TERMS; k++)
    begin : g_cell
        tss_cell #(
            .K (k)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .en         (en),
            .term_count (term_count_reg),
            .in_valid   (link_valid[k]),
            .in_link    (link[k]),
            .out_valid  (link_valid[k+1]),
            .out_link   (link[k+1])
        );
    end

    tss_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (link_valid[MAX_TERMS+1]),
        .in_link   (link[MAX_TERMS+1]),
        .out_valid (m_tvalid),
        .sine      (m_tdata),
        .saturated (m_tuser)
    );

endmodule

@@ dv/taylor_series_sine_tb.sv @@
module taylor_series_sine_tb;

    import tss_pkg::*;

    localparam int MAX_TERMS = MAX_TERMS_DEF;
    localparam int N_PHASES  = 9;
    localparam int RX_HOLD   = 200;

    // one expected result, with the angle kept for reporting
    typedef struct packed {
        logic [ANGLE_W-1:0] angle;
        logic [SINE_W-1:0]  sine;
        logic               sat;
    } sine_res_t;

    logic                clk;
    logic                rst_n     = 1'b0;
    logic                s_tvalid  = 1'b0;
    logic                s_tready;
    logic [ANGLE_W-1:0]  s_tdata   = '0;    // [31:0] angle
    logic                m_tvalid;
    logic                m_tready  = 1'b0;
    logic [SINE_W-1:0]   m_tdata;           // [31:0] sine
    logic                m_tuser;           // [0] saturated
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [CNT_W-1:0]    cfg_data  = '0;

    // stimulus and expected results
    logic [ANGLE_W-1:0]  angle_q [$];
    sine_res_t           sine_q [$];
    sine_res_t           rx_want;
    logic [CNT_W-1:0]    active_terms = TERM_COUNT_RST;

    // idle control
    logic                tx_quiet     = 1'b0;
    logic                quiet_all    = 1'b0;
    logic                rx_hold_arm  = 1'b0;
    logic                rx_hold_done = 1'b0;
    int                  rx_hold_left  = 0;
    int                  rx_stall_left = 0;
    int                  tx_gap_left   = 0;

    // bookkeeping
    int                  n_sent    = 0;
    int                  n_checked = 0;
    int                  n_errors  = 0;
    int                  n_sat     = 0;
    int                  n_blocked = 0;

    logic [CNT_W-1:0]    plan_terms [0:N_PHASES-1] = '{4'd10, 4'd0, 4'd15, 4'd1, 4'd5, 4'd11,
                                                       4'd3, 4'd7, 4'd10};
    int                  plan_items [0:N_PHASES-1] = '{140, 100, 140, 100, 110, 100, 100, 100, 120};

    taylor_series_sine #(
        .MAX_TERMS (MAX_TERMS)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // truncated maclaurin sine on |x|/8 with scaled reciprocal factorials
    function automatic sine_res_t series_sine(input logic [ANGLE_W-1:0] angle,
                                              input logic [CNT_W-1:0] terms);
        logic [127:0]      wide;
        logic [127:0]      dvs;
        logic [63:0]       u;
        logic [63:0]       u2;
        logic [63:0]       pw;
        logic [63:0]       coef;
        logic [63:0]       mag;
        logic [63:0]       r;
        logic [63:0]       lim;
        logic [31:0]       amag;
        logic signed [63:0] acc;
        logic [52:0]       term_v [0:TERMS_LIM];
        logic              neg_in;
        logic              neg_out;
        int                last;
        sine_res_t         res;
        neg_in = angle[ANGLE_W-1];
        amag   = neg_in ? -angle : angle;
        last   = (terms > MAX_TERMS) ? MAX_TERMS : int'(terms);
        u      = {amag, 32'd0};
        wide   = {64'd0, u} * {64'd0, u};
        u2     = wide[126:63];
        pw     = u;
        coef   = 64'd8 << 52;
        for (int k = 0; k <= last; k++)
        begin
            if (k > 0)
            begin
                dvs  = 128'((2 * k) * (2 * k + 1));
                wide = ({64'd0, coef} << 6) / dvs;
                coef = wide[63:0];
                wide = {64'd0, pw} * {64'd0, u2};
                pw   = wide[126:63];
            end
            wide      = {64'd0, pw} * {64'd0, coef};
            term_v[k] = wide[127:75];
        end
        // alternate signs, highest term first
        acc = '0;
        for (int k = last; k >= 0; k--)
        begin
            if (k % 2 == 1)
                acc = acc - $signed({11'd0, term_v[k]});
            else
                acc = acc + $signed({11'd0, term_v[k]});
        end
        // round half away from zero, then clamp to q2.30
        mag     = acc[63] ? -acc : acc;
        r       = (mag + 64'd512) >> RND_SH;
        neg_out = (acc[63] != neg_in) && (r != 0);
        lim     = neg_out ? 64'h8000_0000 : 64'h7FFF_FFFF;
        res.sat = (r > lim);
        if (res.sat)
            r = lim;
        res.angle = angle;
        res.sine  = neg_out ? -r[31:0] : r[31:0];
        return res;
    endfunction

    // mixes corners, small and mid magnitudes and full-range words
    function automatic logic [ANGLE_W-1:0] rand_angle();
        logic [31:0] mag;
        case ($urandom_range(0, 7))
            0: begin
                case ($urandom_range(0, 5))
                    0: mag = 32'h7FFF_FFFF;
                    1: mag = 32'h8000_0000;
                    2: mag = 32'h2000_0000;
                    3: mag = 32'h1FFF_FFFF;
                    4: mag = 32'h0000_0001;
                    default: mag = 32'h0;
                endcase
                return $urandom_range(0, 1) ? -mag : mag;
            end
            1, 2: begin
                mag = $urandom_range(0, 32'h2000_0000);
                return $urandom_range(0, 1) ? -mag : mag;
            end
            3: begin
                mag = $urandom_range(0, 32'h4000_0000);
                return $urandom_range(0, 1) ? -mag : mag;
            end
            default: return $urandom;
        endcase
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // sender: random gaps, expectation computed on every accepted beat
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                sine_q.push_back(series_sine(s_tdata, active_terms));
                n_sent++;
            end
            if (s_tvalid && !s_tready)
            begin
                n_blocked++;
            end
            else if (tx_gap_left != 0)
            begin
                tx_gap_left <= tx_gap_left - 1;
                s_tvalid    <= 1'b0;
            end
            else if (!tx_quiet && !quiet_all && $urandom_range(0, 7) == 0)
            begin
                tx_gap_left <= $urandom_range(0, 9);
                s_tvalid    <= 1'b0;
            end
            else if (angle_q.size() != 0)
            begin
                s_tdata  <= angle_q.pop_front();
                s_tvalid <= 1'b1;
            end
            else
            begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // receiver: compare each beat, then pick next ready
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (sine_q.size() == 0)
                begin
                    $display("%0t: unexpected result sine %h sat %b", $time, m_tdata, m_tuser);
                    n_errors++;
                end
                else
                begin
                    rx_want = sine_q.pop_front();
                    if (m_tdata !== rx_want.sine)
                    begin
                        $display("%0t: angle %h sine expected %h actual %h",
                                 $time, rx_want.angle, rx_want.sine, m_tdata);
                        n_errors++;
                    end
                    if (m_tuser !== rx_want.sat)
                    begin
                        $display("%0t: angle %h saturated expected %b actual %b",
                                 $time, rx_want.angle, rx_want.sat, m_tuser);
                        n_errors++;
                    end
                    if (rx_want.sat)
                        n_sat++;
                    n_checked++;
                end
            end
            if (rx_hold_left != 0)
            begin
                rx_hold_left <= rx_hold_left - 1;
                m_tready     <= 1'b0;
            end
            else if (rx_hold_arm && !rx_hold_done && m_tvalid)
            begin
                rx_hold_left <= RX_HOLD;
                rx_hold_done <= 1'b1;
                m_tready     <= 1'b0;
            end
            else if (rx_stall_left != 0)
            begin
                rx_stall_left <= rx_stall_left - 1;
                m_tready      <= 1'b0;
            end
            else if (!quiet_all && $urandom_range(0, 5) == 0)
            begin
                rx_stall_left <= $urandom_range(0, 9);
                m_tready      <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
            end
        end
    end

    // wait until every queued angle has gone in and every result is back
    task automatic drain_all();
        while (angle_q.size() != 0 || s_tvalid || n_checked != n_sent)
            @(negedge clk);
    endtask

    task automatic write_term_count(input logic [CNT_W-1:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid    <= 1'b0;
        active_terms = value;
        @(negedge clk);
    endtask

    task automatic push_corners();
        angle_q.push_back(32'h7FFF_FFFF);
        angle_q.push_back(32'h8000_0000);
        angle_q.push_back(32'h2000_0000);
        angle_q.push_back(32'hE000_0000);
        angle_q.push_back(32'h1FFF_FFFF);
        angle_q.push_back(32'h0000_0000);
    endtask

    // main sequence: directed angles, then random phases over term_count settings
    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (int ph = 0; ph < N_PHASES; ph++)
        begin
            if (ph > 0)
            begin
                drain_all();
                write_term_count(plan_terms[ph]);
            end
            if (ph == 0)
            begin
                angle_q.push_back(32'h0000_0000);
                angle_q.push_back(32'h0000_0001);
                angle_q.push_back(32'hFFFF_FFFF);
                angle_q.push_back(32'h0000_0200);
                angle_q.push_back(32'h7FFF_FFFF);
                angle_q.push_back(32'h7FFF_FFFE);
                angle_q.push_back(32'h8000_0000);
                angle_q.push_back(32'h8000_0001);
                angle_q.push_back(32'h1921_FB54);   // pi/2
                angle_q.push_back(32'hE6DE_04AC);   // -pi/2
                angle_q.push_back(32'h3243_F6A9);   // pi
                angle_q.push_back(32'hCDBC_0957);   // -pi
                angle_q.push_back(32'h6487_ED51);   // 2*pi
                angle_q.push_back(32'h1000_0000);
                angle_q.push_back(32'hF000_0000);
                angle_q.push_back(32'h2000_0000);
                angle_q.push_back(32'h4000_0000);
                angle_q.push_back(32'hC000_0000);
                angle_q.push_back(32'h5555_5555);
                angle_q.push_back(32'hAAAA_AAAA);
            end
            else
            begin
                push_corners();
            end
            // fill the pipe against a long receiver hold
            if (ph == 2)
            begin
                tx_quiet    = 1'b1;
                rx_hold_arm = 1'b1;
            end
            if (ph == N_PHASES - 1)
                quiet_all = 1'b1;
            for (int i = 0; i < plan_items[ph]; i++)
                angle_q.push_back(rand_angle());
            if (ph == 2)
            begin
                drain_all();
                tx_quiet    = 1'b0;
                rx_hold_arm = 1'b0;
            end
        end

        drain_all();
        repeat (3 * MAX_TERMS + 20) @(posedge clk);

        $display("summary: %0d angles checked over %0d term_count phases (0, 1, 3, 5, 7, 10, 11, 15)",
                 n_checked, N_PHASES);
        $display("summary: %0d saturated results, %0d input backpressure cycles",
                 n_sat, n_blocked);
        if (n_errors == 0 && sine_q.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // watchdog
    initial
    begin
        #4000000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

@@ taylor_series_sine.f @@
hw/rtl/tss_pkg.sv
hw/rtl/tss_front.sv
hw/rtl/tss_cell.sv
hw/rtl/tss_back.sv
hw/rtl/taylor_series_sine.sv
dv/taylor_series_sine_tb.sv
